// ===== hw/rtl/lzsc_pkg.sv =====
// Shared constants and types for the LZSS decompressor with sum check.
package lzsc_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int MAX_RUN     = 18;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);
  localparam int CNT_W       = WIN_AW + 1;
  localparam int RUN_W       = $clog2(MAX_RUN + 1);
  localparam int LEN_BASE    = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_LENGTH = 2'd0,
    CFG_SIGNED_SUM    = 2'd1,
    CFG_VERIFY_ENABLE = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    PH_FLAG   = 6'b000001,
    PH_ITEM   = 6'b000010,
    PH_PTR_HI = 6'b000100,
    PH_RUN    = 6'b001000,
    PH_SUM    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
  } hist_req_t;

  typedef struct packed {
    logic [31:0] output_length;
    logic        signed_sum_mode;
    logic        verify_enable;
  } cfg_t;

endpackage

// ===== hw/rtl/lzsc_if.sv =====
// Request channel interfaces: compressed input, decoded output, register writes.
interface lzsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       block_start;
  modport source (output valid, output in_byte, output block_start, input ready);
  modport sink   (input valid, input in_byte, input block_start, output ready);
endinterface

interface lzsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       block_done;
  logic       checksum_bad;
  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output block_done, output checksum_bad, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input block_done, input checksum_bad, output ready);
endinterface

interface lzsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lzsc_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lzsc_hist_ram.sv =====
// History window RAM: one write port, one registered read port.
module lzsc_hist_ram (
  input  logic                clk,
  input  lzsc_pkg::hist_req_t req,
  output logic [7:0]          rdata
);

  logic [7:0] mem [lzsc_pkg::WINDOW_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== hw/rtl/lzsc_decoder.sv =====
// Stream decoder: flag/literal/pointer parsing, copy sequencer, byte sum and check.
module lzsc_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  lzsc_pkg::cfg_t      cfg,
  lzsc_in_if.sink             in_chan,
  lzsc_out_if.source          out_chan,
  output lzsc_pkg::hist_req_t hist_req,
  input  logic [7:0]          hist_rdata
);

  localparam int AW = lzsc_pkg::WIN_AW;
  localparam int CW = lzsc_pkg::CNT_W;
  localparam int RW = lzsc_pkg::RUN_W;

  lzsc_pkg::phase_t phase_r, phase_nxt;
  logic [8:0]    flags_r, flags_nxt;
  logic [7:0]    ptr_low_r, ptr_low_nxt;
  logic [31:0]   bytes_left_r, bytes_left_nxt;
  logic [CW-1:0] produced_r, produced_nxt;
  logic [31:0]   run_sum_r, run_sum_nxt;
  logic [31:0]   recv_sum_r, recv_sum_nxt;
  logic [1:0]    sum_idx_r, sum_idx_nxt;
  logic [AW-1:0] wr_pos_r, wr_pos_nxt;
  logic [AW-1:0] dist_r, dist_nxt;
  logic [RW-1:0] run_left_r, run_left_nxt;
  logic          fwd_r, fwd_nxt;
  logic [7:0]    fwd_data_r, fwd_data_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       obv_r, obv_nxt;
  logic       olast_r, olast_nxt;
  logic       odone_r, odone_nxt;
  logic       obad_r, obad_nxt;

  logic slot_free;
  logic acc;

  assign slot_free     = !ov_r || out_chan.ready;
  assign in_chan.ready = (phase_r != lzsc_pkg::PH_RUN) && slot_free;
  assign acc           = in_chan.valid && in_chan.ready;

  assign out_chan.valid        = ov_r;
  assign out_chan.out_byte     = ob_r;
  assign out_chan.byte_valid   = obv_r;
  assign out_chan.run_last     = olast_r;
  assign out_chan.block_done   = odone_r;
  assign out_chan.checksum_bad = obad_r;

  always_comb begin
    lzsc_pkg::phase_t ph_e;
    logic [8:0]    fl_e;
    logic [31:0]   bl_e;
    logic [CW-1:0] pc_e;
    logic [31:0]   rs_e;
    logic [31:0]   rc_e;
    logic [1:0]    si_e;
    logic [AW-1:0] wp_e;
    logic          pe;
    logic [7:0]    pv;
    logic          p_last;
    logic          p_item_end;
    logic          fin;
    logic [31:0]   bl_dec;
    logic [31:0]   ext;
    logic [31:0]   rc_new;
    logic [7:0]    rd_byte;
    logic          run_end;
    logic [AW-1:0] rd_addr;
    logic [8:0]    fl_sh;

    ph_e = phase_r;
    fl_e = flags_r;
    bl_e = bytes_left_r;
    pc_e = produced_r;
    rs_e = run_sum_r;
    rc_e = recv_sum_r;
    si_e = sum_idx_r;
    wp_e = wr_pos_r;

    pe         = 1'b0;
    pv         = 8'h00;
    p_last     = 1'b0;
    p_item_end = 1'b0;
    ext        = 32'h0;
    rc_new     = 32'h0;
    rd_byte    = fwd_r ? fwd_data_r : hist_rdata;
    run_end    = 1'b0;
    rd_addr    = '0;
    fl_sh      = 9'h0;

    ptr_low_nxt  = ptr_low_r;
    dist_nxt     = dist_r;
    run_left_nxt = run_left_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    hist_req     = '0;

    ov_nxt    = ov_r && !out_chan.ready;
    ob_nxt    = ob_r;
    obv_nxt   = obv_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    obad_nxt  = obad_r;

    // block start clears state before the byte is parsed
    if (acc && in_chan.block_start) begin
      fl_e = '0;
      pc_e = '0;
      rs_e = '0;
      rc_e = '0;
      si_e = '0;
      wp_e = '0;
      bl_e = cfg.output_length;
      ph_e = lzsc_pkg::PH_FLAG;
      if (cfg.output_length == 32'h0) begin
        if (cfg.verify_enable) begin
          ph_e = lzsc_pkg::PH_SUM;
        end else begin
          ph_e      = lzsc_pkg::PH_DONE;
          ov_nxt    = 1'b1;
          ob_nxt    = 8'h00;
          obv_nxt   = 1'b0;
          olast_nxt = 1'b1;
          odone_nxt = 1'b1;
          obad_nxt  = 1'b0;
        end
      end
    end

    phase_nxt      = ph_e;
    flags_nxt      = fl_e;
    bytes_left_nxt = bl_e;
    produced_nxt   = pc_e;
    run_sum_nxt    = rs_e;
    recv_sum_nxt   = rc_e;
    sum_idx_nxt    = si_e;
    wr_pos_nxt     = wp_e;

    bl_dec = bl_e - 32'd1;
    fin    = (bl_dec == 32'h0);

    if (acc) begin
      unique case (ph_e)
        lzsc_pkg::PH_FLAG: begin
          if (bl_e != 32'h0) begin
            flags_nxt = {1'b1, in_chan.in_byte};
            phase_nxt = lzsc_pkg::PH_ITEM;
          end
        end
        lzsc_pkg::PH_ITEM: begin
          if (bl_e != 32'h0) begin
            if (fl_e[0]) begin
              pe         = 1'b1;
              pv         = in_chan.in_byte;
              p_last     = 1'b1;
              p_item_end = 1'b1;
            end else begin
              ptr_low_nxt = in_chan.in_byte;
              phase_nxt   = lzsc_pkg::PH_PTR_HI;
            end
          end
        end
        lzsc_pkg::PH_PTR_HI: begin
          if (bl_e != 32'h0) begin
            dist_nxt     = {in_chan.in_byte[7:4], ptr_low_r};
            run_left_nxt = RW'(in_chan.in_byte[3:0]) + RW'(lzsc_pkg::LEN_BASE);
            hist_req.re    = 1'b1;
            hist_req.raddr = wp_e - {in_chan.in_byte[7:4], ptr_low_r};
            fwd_nxt      = 1'b0;
            phase_nxt    = lzsc_pkg::PH_RUN;
          end
        end
        lzsc_pkg::PH_SUM: begin
          rc_new       = rc_e | ({24'h0, in_chan.in_byte} << {si_e, 3'b000});
          recv_sum_nxt = rc_new;
          if (si_e == 2'd3) begin
            sum_idx_nxt = 2'd0;
            phase_nxt   = lzsc_pkg::PH_DONE;
            ov_nxt      = 1'b1;
            ob_nxt      = 8'h00;
            obv_nxt     = 1'b0;
            olast_nxt   = 1'b1;
            odone_nxt   = 1'b1;
            obad_nxt    = (rc_new != rs_e);
          end else begin
            sum_idx_nxt = si_e + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end else if (phase_r == lzsc_pkg::PH_RUN && slot_free) begin
      if ({1'b0, dist_r} > pc_e) begin
        pv = lzsc_pkg::SPACE_BYTE;
      end else if (dist_r == '0) begin
        pv = 8'h00;
      end else begin
        pv = rd_byte;
      end
      pe      = 1'b1;
      run_end = (run_left_r == RW'(1)) || fin;
      p_last  = run_end;
      if (run_end) begin
        p_item_end = 1'b1;
      end else begin
        run_left_nxt   = run_left_r - RW'(1);
        rd_addr        = wp_e + AW'(1) - dist_r;
        hist_req.re    = 1'b1;
        hist_req.raddr = rd_addr;
        // read of the entry written this same cycle
        fwd_nxt        = (rd_addr == wp_e);
        fwd_data_nxt   = pv;
      end
    end

    if (pe) begin
      ext = (cfg.signed_sum_mode && pv[7]) ? {24'hffffff, pv} : {24'h0, pv};
      run_sum_nxt    = rs_e + ext;
      hist_req.we    = 1'b1;
      hist_req.waddr = wp_e;
      hist_req.wdata = pv;
      wr_pos_nxt     = wp_e + AW'(1);
      if (pc_e < CW'(lzsc_pkg::WINDOW_SIZE)) begin
        produced_nxt = pc_e + CW'(1);
      end
      bytes_left_nxt = bl_dec;
      ov_nxt    = 1'b1;
      ob_nxt    = pv;
      obv_nxt   = 1'b1;
      olast_nxt = p_last;
      odone_nxt = fin && !cfg.verify_enable;
      obad_nxt  = 1'b0;
      if (fin) begin
        phase_nxt = cfg.verify_enable ? lzsc_pkg::PH_SUM : lzsc_pkg::PH_DONE;
      end else if (p_item_end) begin
        fl_sh     = fl_e >> 1;
        flags_nxt = fl_sh;
        phase_nxt = (fl_sh == 9'd1) ? lzsc_pkg::PH_FLAG : lzsc_pkg::PH_ITEM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lzsc_pkg::PH_FLAG;
      flags_r      <= '0;
      ptr_low_r    <= '0;
      bytes_left_r <= '0;
      produced_r   <= '0;
      run_sum_r    <= '0;
      recv_sum_r   <= '0;
      sum_idx_r    <= '0;
      wr_pos_r     <= '0;
      run_left_r   <= '0;
      fwd_r        <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      flags_r      <= flags_nxt;
      ptr_low_r    <= ptr_low_nxt;
      bytes_left_r <= bytes_left_nxt;
      produced_r   <= produced_nxt;
      run_sum_r    <= run_sum_nxt;
      recv_sum_r   <= recv_sum_nxt;
      sum_idx_r    <= sum_idx_nxt;
      wr_pos_r     <= wr_pos_nxt;
      run_left_r   <= run_left_nxt;
      fwd_r        <= fwd_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    fwd_data_r <= fwd_data_nxt;
    ob_r       <= ob_nxt;
    obv_r      <= obv_nxt;
    olast_r    <= olast_nxt;
    odone_r    <= odone_nxt;
    obad_r     <= obad_nxt;
  end

endmodule

// ===== hw/rtl/lzss_decompressor_with_sum_check_core.sv =====
// LZSS decompressor top level (4 KiB window) with trailing byte-sum check.
// One compressed byte is taken per request on in_chan; flag, literal, pointer-low and
// checksum bytes are each decoded as they are taken. A pointer's high byte starts the
// history read, then the copy emits its 3 to 18 bytes (fewer when the block length runs
// out) at one byte per cycle, paced by the single read port of the 4096-byte history RAM
// (read data forwarded when a copy reads the byte just written). Each result shows on
// out_chan the cycle after the edge that produced it.
// No input is taken while a copy runs or while an undelivered result blocks the output
// register. Back-pressure on out_chan stalls the copy. The history needs no clearing
// after reset: only entries written in the current block are ever used.
// Registers: 0 output_length, 1 signed_sum_mode, 2 verify_enable (reset 0, 0, 1);
// writes are always accepted and apply from the next request; a write during a copy
// also changes the rest of that copy, so write only while no copy runs.
module lzss_decompressor_with_sum_check_core (
  input  logic        clk,
  input  logic        rst_n,
  lzsc_cfg_if.sink    cfg_chan,
  lzsc_in_if.sink     in_chan,
  lzsc_out_if.source  out_chan
);

  lzsc_pkg::cfg_t      cfg_r;
  lzsc_pkg::cfg_t      cfg_nxt;
  lzsc_pkg::hist_req_t hist_req;
  logic [7:0]          hist_rdata;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (lzsc_pkg::cfg_idx_t'(cfg_chan.index))
        lzsc_pkg::CFG_OUTPUT_LENGTH: cfg_nxt.output_length   = cfg_chan.data;
        lzsc_pkg::CFG_SIGNED_SUM:    cfg_nxt.signed_sum_mode = cfg_chan.data[0];
        lzsc_pkg::CFG_VERIFY_ENABLE: cfg_nxt.verify_enable   = cfg_chan.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_length   <= 32'h0;
      cfg_r.signed_sum_mode <= 1'b0;
      cfg_r.verify_enable   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lzsc_decoder u_decoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .hist_req   (hist_req),
    .hist_rdata (hist_rdata)
  );

  lzsc_hist_ram u_hist_ram (
    .clk   (clk),
    .req   (hist_req),
    .rdata (hist_rdata)
  );

endmodule

// ===== dv/tb_lzss_decompressor_with_sum_check_core.sv =====
// Self-checking testbench for the LZSS decompressor core with trailing byte-sum check.
`timescale 1ns / 1ps

module tb_lzss_decompressor_with_sum_check_core;

  typedef struct packed {
    logic [7:0] data;
    logic       dv;
    logic       last;
    logic       done;
    logic       bad;
  } dec_out_t;

  typedef struct {
    logic [7:0]  b;
    logic        st;
    logic        is_sum;
    int          k;
    logic [31:0] flip;
  } lz_req_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_vld = 1'b0;
  logic [7:0]           in_byte_r = 8'h00;
  logic                 in_st_r = 1'b0;
  logic                 out_rdy = 1'b0;
  logic                 cfg_vld = 1'b0;
  lzsc_pkg::cfg_idx_t   cfg_idx = lzsc_pkg::CFG_OUTPUT_LENGTH;
  logic [31:0]          cfg_dat = 32'd0;

  lzsc_in_if  in_chan();
  lzsc_out_if out_chan();
  lzsc_cfg_if cfg_chan();

  assign in_chan.valid       = in_vld;
  assign in_chan.in_byte     = in_byte_r;
  assign in_chan.block_start = in_st_r;
  assign out_chan.ready      = out_rdy;
  assign cfg_chan.valid      = cfg_vld;
  assign cfg_chan.index      = cfg_idx;
  assign cfg_chan.data       = cfg_dat;

  lzss_decompressor_with_sum_check_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // decoder shadow state
  logic [31:0]                 len_cfg = 32'd0;
  logic                        sgn_cfg = 1'b0;
  logic                        chk_cfg = 1'b1;
  logic [7:0]                  win_mem [lzsc_pkg::WINDOW_SIZE];
  logic [15:0]                 flag_sr = '0;
  lzsc_pkg::phase_t            dec_phase = lzsc_pkg::PH_FLAG;
  logic [7:0]                  ptr_lo_q = '0;
  logic [31:0]                 remaining = '0;
  logic [lzsc_pkg::CNT_W-1:0]  emitted = '0;
  logic [31:0]                 sum_acc = '0;
  logic [31:0]                 sum_rx = '0;
  logic [1:0]                  sum_pos = '0;
  logic [lzsc_pkg::WIN_AW-1:0] wr_ptr = '0;

  dec_out_t step_q[$];
  dec_out_t exp_q[$];
  lz_req_t  req_q[$];

  int          pending = 0;
  int          errs = 0;
  int          rand_items = 0;
  int          n_in = 0;
  int          n_bytes = 0;
  int          n_blocks = 0;
  int          n_bad = 0;
  int          n_settings = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          pressure_go = 1'b0;
  bit          out_hold = 1'b0;
  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  lz_req_t     cur;
  logic [31:0] req_word;
  dec_out_t    got;
  dec_out_t    want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_fail(string msg);
    errs++;
    if (errs <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic push_res(logic [7:0] d, logic dv, logic done, logic bad);
    dec_out_t r;
    r = '{data: d, dv: dv, last: 1'b0, done: done, bad: bad};
    step_q = {step_q, r};
  endtask

  task automatic emit_byte(logic [7:0] v);
    if (sgn_cfg && v[7]) begin
      sum_acc = sum_acc + {24'hff_ffff, v};
    end else begin
      sum_acc = sum_acc + {24'd0, v};
    end
    win_mem[wr_ptr] = v;
    wr_ptr = wr_ptr + 1'b1;
    if (emitted < lzsc_pkg::WINDOW_SIZE) emitted = emitted + 1'b1;
    remaining = remaining - 1;
    if (remaining == 0) dec_phase = chk_cfg ? lzsc_pkg::PH_SUM : lzsc_pkg::PH_DONE;
    push_res(v, 1'b1, dec_phase == lzsc_pkg::PH_DONE, 1'b0);
  endtask

  task automatic next_sel();
    flag_sr = flag_sr >> 1;
    dec_phase = flag_sr[8] ? lzsc_pkg::PH_ITEM : lzsc_pkg::PH_FLAG;
  endtask

  // one compressed byte through the shadow decoder; results go to exp_q
  task automatic decode_byte(logic [7:0] b, logic st);
    logic [lzsc_pkg::WIN_AW-1:0] back;
    logic [lzsc_pkg::WIN_AW-1:0] rd_addr;
    logic [7:0]                  v;
    int                          run;
    step_q.delete();
    if (st) begin
      flag_sr = '0;
      ptr_lo_q = '0;
      emitted = '0;
      sum_acc = '0;
      sum_rx = '0;
      sum_pos = '0;
      wr_ptr = '0;
      remaining = len_cfg;
      dec_phase = lzsc_pkg::PH_FLAG;
      if (remaining == 0) begin
        dec_phase = chk_cfg ? lzsc_pkg::PH_SUM : lzsc_pkg::PH_DONE;
        if (dec_phase == lzsc_pkg::PH_DONE) push_res(8'h00, 1'b0, 1'b1, 1'b0);
      end
    end
    case (dec_phase)
      lzsc_pkg::PH_FLAG: begin
        if (remaining != 0) begin
          flag_sr = {8'hff, b};
          dec_phase = lzsc_pkg::PH_ITEM;
        end
      end
      lzsc_pkg::PH_ITEM: begin
        if (remaining != 0) begin
          if (flag_sr[0]) begin
            emit_byte(b);
            if (remaining != 0) next_sel();
          end else begin
            ptr_lo_q = b;
            dec_phase = lzsc_pkg::PH_PTR_HI;
          end
        end
      end
      lzsc_pkg::PH_PTR_HI: begin
        if (remaining != 0) begin
          back = {b[7:4], ptr_lo_q};
          run = int'(b[3:0]) + lzsc_pkg::LEN_BASE;
          for (int i = 0; i < run && i < lzsc_pkg::MAX_RUN && remaining != 0; i++) begin
            rd_addr = wr_ptr - back;
            if (back > emitted) begin
              v = lzsc_pkg::SPACE_BYTE;
            end else if (back == 0) begin
              v = 8'h00;
            end else begin
              v = win_mem[rd_addr];
            end
            emit_byte(v);
          end
          if (remaining != 0) next_sel();
        end
      end
      lzsc_pkg::PH_SUM: begin
        sum_rx = sum_rx | ({24'd0, b} << (8 * sum_pos));
        if (sum_pos == 2'd3) begin
          sum_pos = '0;
          dec_phase = lzsc_pkg::PH_DONE;
          push_res(8'h00, 1'b0, 1'b1, sum_rx != sum_acc);
        end else begin
          sum_pos = sum_pos + 1'b1;
        end
      end
      default: ;
    endcase
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].last = 1'b1;
    end
    exp_q = {exp_q, step_q};
  endtask

  // sample handshakes, predict and check
  always @(posedge clk) begin
    in_fire <= in_vld && in_chan.ready;
    cfg_fire <= cfg_vld && cfg_chan.ready;
    if (rst_n && cfg_vld && cfg_chan.ready) begin
      case (cfg_idx)
        lzsc_pkg::CFG_OUTPUT_LENGTH: len_cfg = cfg_dat;
        lzsc_pkg::CFG_SIGNED_SUM:    sgn_cfg = cfg_dat[0];
        lzsc_pkg::CFG_VERIFY_ENABLE: chk_cfg = cfg_dat[0];
        default: ;
      endcase
    end
    if (rst_n && in_vld && in_chan.ready) begin
      decode_byte(in_byte_r, in_st_r);
      pending--;
      n_in++;
    end
    if (rst_n && out_chan.valid && out_rdy) begin
      got = '{data: out_chan.out_byte, dv: out_chan.byte_valid, last: out_chan.run_last,
              done: out_chan.block_done, bad: out_chan.checksum_bad};
      if (exp_q.size() == 0) begin
        note_fail($sformatf("unexpected result byte=%02h valid=%b last=%b done=%b bad=%b",
                            got.data, got.dv, got.last, got.done, got.bad));
      end else begin
        want = exp_q.pop_front();
        if (got.data !== want.data || got.dv !== want.dv || got.last !== want.last ||
            got.done !== want.done || got.bad !== want.bad) begin
          note_fail($sformatf({"exp byte=%02h valid=%b last=%b done=%b bad=%b, ",
                               "got byte=%02h valid=%b last=%b done=%b bad=%b"},
                              want.data, want.dv, want.last, want.done, want.bad,
                              got.data, got.dv, got.last, got.done, got.bad));
        end
        if (want.dv) n_bytes++;
        if (want.done) n_blocks++;
        if (want.bad) n_bad++;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_vld || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_vld <= 1'b0;
      end else if (req_q.size() > 0) begin
        cur = req_q.pop_front();
        if (cur.is_sum) begin
          req_word = (cur.st ? 32'd0 : sum_acc) ^ cur.flip;
          in_byte_r <= req_word[8*cur.k +: 8];
        end else begin
          in_byte_r <= cur.b;
        end
        in_st_r <= cur.st;
        in_vld <= 1'b1;
        in_gap = in_idle_on ? pick_gap() : 0;
      end else begin
        in_vld <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || out_hold) begin
      out_rdy <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_rdy <= 1'b0;
    end else begin
      out_rdy <= 1'b1;
      out_gap = out_idle_on ? pick_gap() : 0;
    end
  end

  // long receiver hold-off while the sender keeps going
  initial begin
    wait (pressure_go);
    @(posedge clk);
    out_hold = 1'b1;
    repeat (300) @(posedge clk);
    out_hold = 1'b0;
  end

  task automatic write_reg(lzsc_pkg::cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_vld <= 1'b1;
    cfg_idx <= idx;
    cfg_dat <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_vld <= 1'b0;
  endtask

  task automatic set_mode(logic [31:0] len, bit sgn, bit chk);
    write_reg(lzsc_pkg::CFG_OUTPUT_LENGTH, len);
    write_reg(lzsc_pkg::CFG_SIGNED_SUM, {31'($urandom_range(0, 32'h7fff_ffff)), sgn});
    write_reg(lzsc_pkg::CFG_VERIFY_ENABLE, {31'($urandom_range(0, 32'h7fff_ffff)), chk});
    n_settings++;
  endtask

  task automatic add_item(logic [7:0] b, logic st, bit counted);
    lz_req_t r;
    r = '{b: b, st: st, is_sum: 1'b0, k: 0, flip: 32'd0};
    req_q = {req_q, r};
    pending++;
    if (counted) rand_items++;
  endtask

  task automatic add_sums(logic [31:0] flip, logic st, bit counted);
    lz_req_t r;
    for (int k = 0; k < 4; k++) begin
      r = '{b: 8'h00, st: (k == 0) ? st : 1'b0, is_sum: 1'b1, k: k, flip: flip};
      req_q = {req_q, r};
      pending++;
      if (counted) rand_items++;
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk); while (pending != 0 || exp_q.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  // well-formed stream for one block; cut > 0 stops once at least that many requests are queued
  task automatic gen_block(logic [31:0] len, bit chk, int cut);
    logic [31:0] made_cnt;
    logic [31:0] left;
    logic [7:0]  flags;
    logic [7:0]  hi;
    logic [31:0] flip;
    int unsigned seen;
    int unsigned back;
    int unsigned r;
    int          n;
    int          run;
    bit          first;
    made_cnt = 0;
    seen = 0;
    n = 0;
    first = 1'b1;
    while (made_cnt < len && (cut == 0 || n < cut)) begin
      r = $urandom_range(0, 9);
      flags = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(0, 255));
      add_item(flags, first, 1'b1);
      first = 1'b0;
      n++;
      for (int i = 0; i < 8 && made_cnt < len && (cut == 0 || n < cut); i++) begin
        if (flags[i]) begin
          add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          n++;
          made_cnt++;
          if (seen < lzsc_pkg::WINDOW_SIZE) seen++;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 30 && seen > 0) begin
            back = $urandom_range(1, (seen > 8) ? 8 : seen);
          end else if (r < 60 && seen > 0) begin
            back = $urandom_range(1, (seen > 4095) ? 4095 : seen);
          end else if (r < 72) begin
            back = 0;
          end else begin
            back = $urandom_range(0, 4095);
          end
          hi = {4'(back >> 8), 4'($urandom_range(0, 15))};
          add_item(8'(back), 1'b0, 1'b1);
          add_item(hi, 1'b0, 1'b1);
          n += 2;
          run = int'(hi[3:0]) + lzsc_pkg::LEN_BASE;
          left = len - made_cnt;
          if (left < run) run = int'(left);
          made_cnt += run;
          seen = (seen + run > lzsc_pkg::WINDOW_SIZE) ? lzsc_pkg::WINDOW_SIZE : seen + run;
        end
      end
    end
    if (made_cnt >= len) begin
      if (chk) begin
        flip = ($urandom_range(0, 3) == 0) ? (32'd1 << $urandom_range(0, 31)) : 32'd0;
        add_sums(flip, first, 1'b1);
      end else if (first) begin
        add_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    logic [31:0] len;
    bit          sgn;
    bit          chk;
    int          ph_no;
    int          nblk;
    int          cut;
    int unsigned r;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: idle bytes, empty blocks, literal extremes, zero / far / overlapping copies
    add_item(8'ha5, 1'b0, 1'b0);
    add_item(8'h5a, 1'b0, 1'b0);
    add_sums(32'd0, 1'b1, 1'b0);
    wait_drain();
    write_reg(lzsc_pkg::CFG_VERIFY_ENABLE, 32'hffff_fffe);
    add_item(8'hff, 1'b1, 1'b0);
    wait_drain();
    set_mode(32'd20, 1'b1, 1'b1);
    add_item(8'h07, 1'b1, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'h80, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'hf1, 1'b0, 1'b0);
    add_item(8'h01, 1'b0, 1'b0);
    add_item(8'h0f, 1'b0, 1'b0);
    add_sums(32'h0000_0100, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b0);
    wait_drain();

    ph_no = 0;
    while (rand_items < 270) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        len = 32'd0;
      end else if (r == 1) begin
        len = 32'hffff_ffff;
      end else if (r == 2) begin
        len = 32'd1;
      end else if (r == 3) begin
        len = $urandom_range(300, 600);
      end else begin
        len = $urandom_range(2, 120);
      end
      sgn = 1'($urandom_range(0, 1));
      chk = ($urandom_range(0, 3) != 0);
      nblk = $urandom_range(1, 3);
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if (ph_no == 0) begin
        len = 32'hffff_ffff;
        sgn = 1'b1;
        nblk = 1;
      end else if (ph_no == 1) begin
        len = 32'd1;
        sgn = 1'b0;
      end else if (ph_no == 2) begin
        len = $urandom_range(150, 250);
        chk = 1'b1;
        nblk = 1;
        in_idle_on = 1'b0;
        out_idle_on = 1'b1;
      end
      set_mode(len, sgn, chk);
      if (ph_no == 2) pressure_go = 1'b1;
      for (int i = 0; i < nblk && (i == 0 || rand_items < 270); i++) begin
        cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 12) : 0;
        if (len == 32'hffff_ffff) cut = $urandom_range(15, 40);
        gen_block(len, chk, cut);
      end
      wait_drain();
      ph_no++;
    end

    $display("Run covered %0d compressed bytes over %0d register settings (both sum modes, ",
             n_in, n_settings + 2);
    $display("  lengths 0..2^32-1): %0d decoded bytes and %0d block ends, %0d with bad sum.",
             n_bytes, n_blocks, n_bad);
    if (errs == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== lzss_decompressor_with_sum_check_core.f =====
hw/rtl/lzsc_pkg.sv
hw/rtl/lzsc_if.sv
hw/rtl/lzsc_hist_ram.sv
hw/rtl/lzsc_decoder.sv
hw/rtl/lzss_decompressor_with_sum_check_core.sv
dv/tb_lzss_decompressor_with_sum_check_core.sv
